// File: hw/rtl/rrs_pkg.sv
// Region range splitter package: transaction types, queue record, status codes.
// No dependencies; used by every module of the splitter.
package rrs_pkg;

  localparam int unsigned ADDR_MAX = 64;
  localparam int unsigned TAG_W    = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned PADDR_W  = 4;
  localparam int unsigned PDATA_W  = 64;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [ADDR_MAX-1:0] addr_t;
  typedef logic [TAG_W-1:0]    tag_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_CUT   = 2'd1;
  localparam status_t ST_ORDER = 2'd2;

  localparam logic KIND_KEEP   = 1'b0;
  localparam logic KIND_DETACH = 1'b1;

  // selected by paddr[3]
  localparam logic REG_CUT_START = 1'b0;
  localparam logic REG_CUT_END   = 1'b1;

  typedef struct packed {
    addr_t region_start;
    addr_t region_end;
    tag_t  region_tag;
    logic  final_region;
  } region_t;

  typedef struct packed {
    addr_t   piece_start;
    addr_t   piece_end;
    tag_t    piece_tag;
    logic    piece_kind;
    status_t status;
    logic    last_piece;
  } piece_t;

  typedef struct packed {
    addr_t   rs;
    addr_t   re;
    addr_t   cs;
    addr_t   ce;
    tag_t    tag;
    status_t status;
    logic    overlap;
    logic    below;
    logic    above;
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: hw/rtl/rrs_front.sv
// Front end: accepts regions, checks cut range and list order, classifies overlap.
// Depends on rrs_pkg; pushes one record per transaction into rrs_queue.
module rrs_front #(
  parameter int unsigned ADDR_WIDTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  rrs_pkg::region_t   region,
  input  logic               region_valid,
  output logic               region_stall,
  input  rrs_pkg::addr_t     cut_start,
  input  rrs_pkg::addr_t     cut_end,
  input  rrs_pkg::q_status_t q_status,
  output logic               push,
  output rrs_pkg::rec_t      rec
);
  import rrs_pkg::*;

  logic [ADDR_WIDTH-1:0] prior_end;
  logic                  failed;
  logic [ADDR_WIDTH-1:0] rs, re, cs, ce;
  logic                  accept, cut_bad, reg_bad;

  assign rs = region.region_start[ADDR_WIDTH-1:0];
  assign re = region.region_end[ADDR_WIDTH-1:0];
  assign cs = cut_start[ADDR_WIDTH-1:0];
  assign ce = cut_end[ADDR_WIDTH-1:0];

  assign cut_bad = (cs >= ce);
  assign reg_bad = failed || (rs >= re) || (rs < prior_end);

  assign region_stall = q_status.full;
  assign accept       = region_valid && !q_status.full;
  assign push         = accept;

  always_comb begin
    rec.rs      = addr_t'(rs);
    rec.re      = addr_t'(re);
    rec.cs      = addr_t'(cs);
    rec.ce      = addr_t'(ce);
    rec.tag     = region.region_tag;
    rec.overlap = !((re <= cs) || (rs >= ce));
    rec.below   = (rs < cs);
    rec.above   = (re > ce);
    if (cut_bad) begin
      rec.status = ST_CUT;
    end else if (reg_bad) begin
      rec.status = ST_ORDER;
    end else begin
      rec.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prior_end <= '0;
      failed    <= 1'b0;
    end else if (accept) begin
      if (region.final_region) begin
        prior_end <= '0;
        failed    <= 1'b0;
      end else if (!cut_bad) begin
        if (reg_bad) begin
          failed <= 1'b1;
        end else begin
          prior_end <= re;
        end
      end
    end
  end

endmodule

// File: hw/rtl/rrs_queue.sv
// Short record queue between front and back end of the splitter.
// Depends on rrs_pkg (rec_t, q_status_t, depth constants).
module rrs_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rrs_pkg::rec_t      wr_rec,
  input  logic               pop,
  output rrs_pkg::rec_t      head,
  output rrs_pkg::q_status_t status
);
  import rrs_pkg::*;

  rec_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head         = entries[rd_ptr];
  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hw/rtl/rrs_back.sv
// Back end: walks the queue head record and emits one piece per cycle while the output is not stalled.
// Depends on rrs_pkg; output register decouples the result channel.
module rrs_back (
  input  logic               clk,
  input  logic               rst,
  input  rrs_pkg::rec_t      head,
  input  rrs_pkg::q_status_t q_status,
  output logic               pop,
  output rrs_pkg::piece_t    piece,
  output logic               piece_valid,
  input  logic               piece_stall
);
  import rrs_pkg::*;

  logic   done_lo, done_mid;
  logic   need_lo, need_hi, split;
  logic   cur_last, cur_is_lo, load;
  piece_t cur;

  assign split   = (head.status == ST_OK) && head.overlap;
  assign need_lo = split && head.below;
  assign need_hi = split && head.above;

  always_comb begin
    cur             = '0;
    cur.piece_tag   = head.tag;
    cur.status      = head.status;
    cur.piece_kind  = KIND_KEEP;
    cur_last        = 1'b1;
    cur_is_lo       = 1'b0;
    if (head.status != ST_OK) begin
      cur.piece_start = '0;
      cur.piece_end   = '0;
    end else if (!head.overlap) begin
      cur.piece_start = head.rs;
      cur.piece_end   = head.re;
    end else if (need_lo && !done_lo) begin
      cur.piece_start = head.rs;
      cur.piece_end   = head.cs;
      cur_last        = 1'b0;
      cur_is_lo       = 1'b1;
    end else if (!done_mid) begin
      cur.piece_start = head.below ? head.cs : head.rs;
      cur.piece_end   = head.above ? head.ce : head.re;
      cur.piece_kind  = KIND_DETACH;
      cur_last        = !need_hi;
    end else begin
      cur.piece_start = head.ce;
      cur.piece_end   = head.re;
    end
    cur.last_piece = cur_last;
  end

  assign load = !q_status.empty && (!piece_valid || !piece_stall);
  assign pop  = load && cur_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      piece_valid <= 1'b0;
      done_lo     <= 1'b0;
      done_mid    <= 1'b0;
    end else begin
      if (load) begin
        piece_valid <= 1'b1;
      end else if (!piece_stall) begin
        piece_valid <= 1'b0;
      end
      if (load) begin
        if (cur_last) begin
          done_lo  <= 1'b0;
          done_mid <= 1'b0;
        end else if (cur_is_lo) begin
          done_lo <= 1'b1;
        end else begin
          done_mid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      piece <= cur;
    end
  end

endmodule

// File: hw/rtl/region_range_splitter_top.sv
// Region range splitter top level: APB cut-range registers, front, queue, back.
// Depends on rrs_pkg, rrs_front, rrs_queue, rrs_back.
//
// Splits each incoming region against the cut range [cut_start, cut_end) into
// up to three pieces (keep below, detach inside, keep above). The front end
// takes a region every cycle while the two-entry queue has room; the back end
// drives one piece per cycle through its output register while piece_stall is
// low. It emits the pieces of a region one after another (three when the region
// straddles both cut edges), so the single result channel sets sustained
// throughput. Error results are a single piece with zero addresses.
// Program cut_start (paddr 0) and cut_end (paddr 8) only while idle.
module region_range_splitter_top #(
  parameter int unsigned ADDR_WIDTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rrs_pkg::region_t              region,
  input  logic                          region_valid,
  output logic                          region_stall,
  output rrs_pkg::piece_t               piece,
  output logic                          piece_valid,
  input  logic                          piece_stall,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rrs_pkg::PADDR_W-1:0]   paddr,
  input  logic [rrs_pkg::PDATA_W-1:0]   pwdata,
  output logic [rrs_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import rrs_pkg::*;

  addr_t     cut_start;
  addr_t     cut_end;
  logic      push, pop;
  rec_t      wr_rec, head;
  q_status_t q_status;

  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[3])
      REG_CUT_START: prdata = cut_start;
      REG_CUT_END:   prdata = cut_end;
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cut_start <= '0;
      cut_end   <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3])
        REG_CUT_START: cut_start <= pwdata;
        REG_CUT_END:   cut_end   <= pwdata;
        default:       ;
      endcase
    end
  end

  rrs_front #(
    .ADDR_WIDTH(ADDR_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .region       (region),
    .region_valid (region_valid),
    .region_stall (region_stall),
    .cut_start    (cut_start),
    .cut_end      (cut_end),
    .q_status     (q_status),
    .push         (push),
    .rec          (wr_rec)
  );

  rrs_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_rec (wr_rec),
    .pop    (pop),
    .head   (head),
    .status (q_status)
  );

  rrs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_status    (q_status),
    .pop         (pop),
    .piece       (piece),
    .piece_valid (piece_valid),
    .piece_stall (piece_stall)
  );

endmodule

// File: hw/rtl/rrs_checker.sv
// Port-level checker for the region range splitter, bound to the top level.
// Depends on rrs_pkg and region_range_splitter_top.
module rrs_checker (
  input logic            clk,
  input logic            rst,
  input rrs_pkg::piece_t piece,
  input logic            piece_valid,
  input logic            piece_stall
);
  import rrs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    piece_valid && piece_stall |=> piece_valid && $stable(piece))
    else $error("stalled piece changed");

  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    piece_valid && (piece.status != ST_OK) |->
      (piece.piece_start == '0) && (piece.piece_end == '0) &&
      (piece.piece_kind == KIND_KEEP) && piece.last_piece)
    else $error("error result not a single empty piece");

  a_ok_nonempty: assert property (@(posedge clk) disable iff (rst)
    piece_valid && (piece.status == ST_OK) |-> piece.piece_start < piece.piece_end)
    else $error("empty piece with ok status");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !piece_valid)
    else $error("piece valid after reset");

endmodule

bind region_range_splitter_top rrs_checker u_rrs_checker (.*);

// File: tb/tb_region_range_splitter_top.sv
// Testbench for region_range_splitter_top: directed and random region lists split
// against cut ranges programmed over APB, each piece checked against a local predictor.
// Depends on rrs_pkg and region_range_splitter_top.
module tb_region_range_splitter_top;
  import rrs_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES    = 80;
  localparam int unsigned SETTLE_CYCLES  = 12;
  localparam logic [63:0] ALL_ONES       = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] TOP_GUARD      = 64'hFFFF_FFFF_FFFF_0000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  region_t             region = '0;
  logic                region_valid = 1'b0;
  logic                region_stall;
  piece_t              piece;
  logic                piece_valid;
  logic                piece_stall = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // predictor state
  logic [63:0] cut_lo = '0;
  logic [63:0] cut_hi = '0;
  logic [63:0] prior_end = '0;
  logic        list_bad = 1'b0;
  piece_t      pieces_due[$];

  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;
  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;
  bit          start_hold = 1'b0;

  region_range_splitter_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .region       (region),
    .region_valid (region_valid),
    .region_stall (region_stall),
    .piece        (piece),
    .piece_valid  (piece_valid),
    .piece_stall  (piece_stall),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] rand_addr();
    return {$urandom, $urandom};
  endfunction

  function automatic region_t mk_region(logic [63:0] rs, logic [63:0] re, tag_t tag,
                                        logic last);
    region_t r;
    r.region_start = rs;
    r.region_end   = re;
    r.region_tag   = tag;
    r.final_region = last;
    return r;
  endfunction

  function automatic piece_t mk_piece(logic [63:0] ps, logic [63:0] pe, tag_t tag,
                                      logic kind, status_t st);
    piece_t p;
    p.piece_start = ps;
    p.piece_end   = pe;
    p.piece_tag   = tag;
    p.piece_kind  = kind;
    p.status      = st;
    p.last_piece  = 1'b0;
    return p;
  endfunction

  function automatic void append_piece(ref piece_t q[$], input piece_t p);
    q.insert(q.size(), p);
  endfunction

  // Splits one accepted region against the current cut range.
  function automatic void split_region(region_t r);
    piece_t      parts[$];
    logic [63:0] lo;
    logic [63:0] hi;
    if (cut_lo >= cut_hi) begin
      append_piece(parts, mk_piece('0, '0, r.region_tag, KIND_KEEP, ST_CUT));
    end else if (list_bad || r.region_start >= r.region_end || r.region_start < prior_end) begin
      list_bad = 1'b1;
      append_piece(parts, mk_piece('0, '0, r.region_tag, KIND_KEEP, ST_ORDER));
    end else begin
      prior_end = r.region_end;
      if (r.region_end <= cut_lo || r.region_start >= cut_hi) begin
        append_piece(parts, mk_piece(r.region_start, r.region_end, r.region_tag, KIND_KEEP,
                                     ST_OK));
      end else begin
        lo = (r.region_start > cut_lo) ? r.region_start : cut_lo;
        hi = (r.region_end < cut_hi) ? r.region_end : cut_hi;
        if (r.region_start < cut_lo)
          append_piece(parts, mk_piece(r.region_start, cut_lo, r.region_tag, KIND_KEEP,
                                       ST_OK));
        append_piece(parts, mk_piece(lo, hi, r.region_tag, KIND_DETACH, ST_OK));
        if (r.region_end > cut_hi)
          append_piece(parts, mk_piece(cut_hi, r.region_end, r.region_tag, KIND_KEEP,
                                       ST_OK));
      end
    end
    parts[parts.size()-1].last_piece = 1'b1;
    foreach (parts[i]) append_piece(pieces_due, parts[i]);
    if (r.final_region) begin
      prior_end = '0;
      list_bad  = 1'b0;
    end
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_piece(piece_t got);
    piece_t want;
    if (pieces_due.size() == 0) begin
      $display("%0t: unexpected piece, expected none, actual %h", $time, got);
      mismatches++;
    end else begin
      want = pieces_due.pop_front();
      check_field("piece_start", want.piece_start, got.piece_start);
      check_field("piece_end", want.piece_end, got.piece_end);
      check_field("piece_tag", 64'(want.piece_tag), 64'(got.piece_tag));
      check_field("piece_kind", 64'(want.piece_kind), 64'(got.piece_kind));
      check_field("status", 64'(want.status), 64'(got.status));
      check_field("last_piece", 64'(want.last_piece), 64'(got.last_piece));
    end
  endtask

  // receiver: checks every transaction and drives stall bursts
  always @(posedge clk) begin
    if (rst) begin
      piece_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (piece_valid && !piece_stall) check_piece(piece);
      if (start_hold) begin
        start_hold = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && stalls_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 13);
      end
      if (stall_left != 0) begin
        piece_stall <= 1'b1;
        stall_left--;
      end else begin
        piece_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (region_valid && !region_stall) || (piece_valid && !piece_stall) || psel) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_region_range_splitter_top failed");
        $finish;
      end
    end
  end

  task automatic write_cut(logic which, logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (which == REG_CUT_START) cut_lo = value;
    else cut_hi = value;
    @(posedge clk);
  endtask

  task automatic set_cut(logic [63:0] lo, logic [63:0] hi);
    write_cut(REG_CUT_START, lo);
    write_cut(REG_CUT_END, hi);
  endtask

  task automatic send_region(region_t r);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      region_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    region       <= r;
    region_valid <= 1'b1;
    do @(posedge clk); while (region_stall);
    split_region(r);
  endtask

  task automatic drain();
    region_valid <= 1'b0;
    while (pieces_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // cut range is 0/0 after reset, so every transaction reports a bad cut
  task automatic test_reset_cut_state();
    send_region(mk_region('0, ALL_ONES, 8'hFF, 1'b0));
    send_region(mk_region(64'h20, 64'h10, 8'h00, 1'b1));
    drain();
  endtask

  task automatic test_split_shapes();
    set_cut(64'h1000, 64'h2000);
    send_region(mk_region(64'h100, 64'h800, 8'h01, 1'b0));
    send_region(mk_region(64'h800, 64'h1000, 8'h02, 1'b0));
    send_region(mk_region(64'h1000, 64'h2000, 8'h03, 1'b1));
    send_region(mk_region(64'h0, 64'h3000, 8'hFF, 1'b1));
    send_region(mk_region(64'hF00, 64'h1800, 8'h80, 1'b0));
    send_region(mk_region(64'h1800, 64'h2800, 8'h7F, 1'b1));
    send_region(mk_region(64'h1200, 64'h1400, 8'h55, 1'b0));
    send_region(mk_region(64'h2000, 64'h2100, 8'hAA, 1'b0));
    send_region(mk_region(64'h3000, ALL_ONES, 8'h00, 1'b1));
    drain();
  endtask

  task automatic test_cut_extremes();
    set_cut('0, ALL_ONES);
    send_region(mk_region('0, ALL_ONES, 8'h5A, 1'b1));
    send_region(mk_region(64'h100, 64'h200, 8'hA5, 1'b0));
    drain();
    // bad cut leaves the open list untouched
    set_cut(64'h40, 64'h40);
    send_region(mk_region(64'h300, 64'h400, 8'h11, 1'b0));
    drain();
    set_cut(64'h80, 64'h40);
    send_region(mk_region(64'h500, 64'h600, 8'h22, 1'b0));
    drain();
    set_cut(64'h1000, 64'h2000);
    send_region(mk_region(64'h150, 64'h300, 8'h33, 1'b1));
    drain();
    set_cut(64'hFFFF_FFFF_FFFF_FF00, ALL_ONES);
    send_region(mk_region(ALL_ONES - 64'h1000, ALL_ONES, 8'hC3, 1'b1));
    drain();
  endtask

  task automatic test_order_errors();
    set_cut(64'h1000, 64'h2000);
    send_region(mk_region(64'h10, 64'h20, 8'h01, 1'b0));
    send_region(mk_region(64'h20, 64'h20, 8'h02, 1'b0));
    send_region(mk_region(64'h30, 64'h40, 8'h03, 1'b0));
    send_region(mk_region(64'h50, 64'h60, 8'h04, 1'b1));
    send_region(mk_region(64'h100, 64'h200, 8'h05, 1'b0));
    send_region(mk_region(64'h200, 64'h300, 8'h06, 1'b0));
    send_region(mk_region(64'h280, 64'h400, 8'h07, 1'b1));
    send_region(mk_region(64'h400, 64'h300, 8'h08, 1'b1));
    send_region(mk_region(64'h800, 64'h1800, 8'h09, 1'b1));
    drain();
  endtask

  // long receiver hold while straddling regions keep coming
  task automatic test_backpressure();
    gaps_on = 1'b0;
    set_cut(64'h1000, 64'h2000);
    start_hold = 1'b1;
    for (int i = 0; i < 12; i++)
      send_region(mk_region(64'h800, 64'h2800, 8'(i), 1'b1));
    drain();
    gaps_on = 1'b1;
  endtask

  task automatic random_lists(int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    logic [63:0] cursor;
    logic [63:0] off;
    logic [63:0] rs;
    logic [63:0] re;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 6);
      if ($urandom_range(0, 3) == 0) begin
        cursor = rand_addr();
      end else begin
        off = 64'($urandom_range(0, 16'h4000));
        cursor = (cut_lo > off) ? cut_lo - off : 64'h0;
      end
      if (cursor > TOP_GUARD) cursor = TOP_GUARD;
      for (int i = 0; i < len && sent < n_items; i++) begin
        rs = cursor + (($urandom_range(0, 2) == 0) ? 64'h0 : 64'($urandom_range(1, 16'h400)));
        re = rs + 64'($urandom_range(1, 16'h1800));
        case ($urandom_range(0, 19))
          0: re = rs;
          1: begin
            off = re;
            re  = rs;
            rs  = off;
          end
          2: if (cursor != 0) rs = cursor - 64'h1;
          3: begin
            rs = rand_addr();
            re = rand_addr();
          end
          default: ;
        endcase
        send_region(mk_region(rs, re, tag_t'($urandom_range(0, 255)),
                              (i == len - 1) && ($urandom_range(0, 9) != 0)));
        cursor = re;
        sent++;
      end
    end
    drain();
  endtask

  task automatic test_random_lists();
    logic [63:0] base;
    base = rand_addr();
    if (base > TOP_GUARD) base = TOP_GUARD;
    set_cut(base, base + 64'($urandom_range(1, 16'h2000)));
    random_lists(20);
    stalls_on = 1'b0;
    base = rand_addr() & 64'h0000_FFFF_FFFF_FFFF;
    set_cut(base, base + 64'h1);
    random_lists(15);
    stalls_on = 1'b1;
    gaps_on   = 1'b0;
    set_cut('0, rand_addr());
    random_lists(20);
    gaps_on = 1'b1;
    set_cut(rand_addr() | 64'h1, 64'h0);
    random_lists(10);
    set_cut(ALL_ONES - 64'h3000, ALL_ONES);
    random_lists(20);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    base = rand_addr();
    if (base > TOP_GUARD) base = TOP_GUARD;
    set_cut(base, base + 64'($urandom_range(16'h100, 16'h3000)));
    random_lists(37);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_cut_state();
    test_split_shapes();
    test_cut_extremes();
    test_order_errors();
    test_backpressure();
    test_random_lists();
    drain();
    if (mismatches == 0) begin
      $display("tb_region_range_splitter_top passed");
    end else begin
      $display("tb_region_range_splitter_top failed");
    end
    $finish;
  end

endmodule
